// File: rtl/fsp_pkg.sv
// Shared types and constants of the flag stable partition block.
// No dependencies; every other file of the block imports this package.
package fsp_pkg;

	localparam int FLAG_W    = 16;
	localparam int MASK_W    = 8;
	localparam int BASE_W    = 16;
	localparam int POS_W     = 6;
	localparam int PP_W      = 17;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 1;

	localparam logic [MASK_W-1:0] FLAG_MASK_RESET   = 8'hFE;
	localparam logic [BASE_W-1:0] BASE_OFFSET_RESET = 16'h0000;

	// Register indexes, taken from the word address of the APB port.
	localparam logic [REG_IDX_W-1:0] REG_FLAG_MASK   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_BASE_OFFSET = 1'b1;

	typedef struct packed {
		logic [MASK_W-1:0] flag_mask;
		logic [BASE_W-1:0] base_offset;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] source_position;
		logic             kept;
		logic [PP_W-1:0]  partition_point;
		logic             overflow;
		logic             last_result;
	} res_t;

endpackage

// File: rtl/fsp_apb_regs.sv
// APB configuration registers: flag mask and base offset.
// Depends on fsp_pkg for widths, reset values and register indexes.
module fsp_apb_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fsp_pkg::APB_AW-1:0] paddr,
	input  logic [fsp_pkg::APB_DW-1:0] pwdata,
	output logic [fsp_pkg::APB_DW-1:0] prdata,
	output logic                      pready,
	output fsp_pkg::cfg_t             cfg
);
	import fsp_pkg::*;

	logic [MASK_W-1:0]    flag_mask_q;
	logic [BASE_W-1:0]    base_offset_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_strobe;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[APB_AW-1:2];
	assign wr_strobe = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_mask_q   <= FLAG_MASK_RESET;
			base_offset_q <= BASE_OFFSET_RESET;
		end else if (wr_strobe) begin
			case (reg_idx)
				REG_FLAG_MASK:   flag_mask_q   <= pwdata[MASK_W-1:0];
				REG_BASE_OFFSET: base_offset_q <= pwdata[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FLAG_MASK:   prdata = {{(APB_DW-MASK_W){1'b0}}, flag_mask_q};
			REG_BASE_OFFSET: prdata = {{(APB_DW-BASE_W){1'b0}}, base_offset_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.flag_mask   = flag_mask_q;
	assign cfg.base_offset = base_offset_q;

endmodule

// File: rtl/fsp_pos_ram.sv
// Store of rejected item positions: one write port, one read port, registered read data.
// Depends on fsp_pkg for the position width.
module fsp_pos_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [fsp_pkg::POS_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [fsp_pkg::POS_W-1:0] rd_data
);
	import fsp_pkg::*;

	logic [POS_W-1:0] mem [DEPTH];
	logic [POS_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds while no read is issued, which lets the drain stall.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/fsp_sequencer.sv
// Block sequencer: mask test, block counters, writes of rejected positions and the drain.
// Depends on fsp_pkg; drives the fsp_pos_ram ports and feeds the output register.
module fsp_sequencer #(
	parameter int MAX_ITEMS = 64,
	parameter int AW        = $clog2(MAX_ITEMS),
	parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fsp_pkg::FLAG_W-1:0] flag_word,
	input  logic                       last_item,
	input  fsp_pkg::cfg_t              cfg,
	input  logic                       out_free,
	output logic                       push,
	output fsp_pkg::res_t              res,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [fsp_pkg::POS_W-1:0]  wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [fsp_pkg::POS_W-1:0]  rd_data
);
	import fsp_pkg::*;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	state_t        state_q;
	logic [CW-1:0] item_q;
	logic [CW-1:0] kept_q;
	logic [CW-1:0] rej_q;
	logic [CW-1:0] drain_q;
	logic          ovf_q;
	logic          rd_valid_s1;
	logic          rd_last_s1;

	logic                accept;
	logic                room;
	logic                pass;
	logic                keep_item;
	logic                rej_item;
	logic                drop;
	logic [CW-1:0]       kept_next;
	logic [CW-1:0]       rej_next;
	logic                drain_pop;
	logic [CW+POS_W-1:0] pos_ext;
	logic [POS_W-1:0]    pos_now;

	assign in_ready  = (state_q == ST_LOAD) && out_free;
	assign accept    = in_valid && in_ready;
	assign room      = item_q < CW'(MAX_ITEMS);
	assign pass      = (flag_word[MASK_W-1:0] & cfg.flag_mask) == '0;
	assign keep_item = accept && room && pass;
	assign rej_item  = accept && room && !pass;
	assign drop      = accept && !room;
	assign kept_next = kept_q + CW'(keep_item);
	assign rej_next  = rej_q + CW'(rej_item);

	// Only the low bits of the position are shown when the block is wider than the port.
	assign pos_ext = {{POS_W{1'b0}}, item_q};
	assign pos_now = pos_ext[POS_W-1:0];

	assign wr_en   = rej_item;
	assign wr_addr = rej_q[AW-1:0];
	assign wr_data = pos_now;

	assign rd_en     = (state_q == ST_DRAIN) && (drain_q < rej_q) && (!rd_valid_s1 || out_free);
	assign rd_addr   = drain_q[AW-1:0];
	assign drain_pop = (state_q == ST_DRAIN) && rd_valid_s1 && out_free;
	assign push      = keep_item || drain_pop;

	always_comb begin
		if (drain_pop) begin
			res.source_position = rd_data;
			res.kept            = 1'b0;
			res.partition_point = PP_W'(cfg.base_offset) + PP_W'(kept_q);
			res.overflow        = ovf_q;
			res.last_result     = rd_last_s1;
		end else begin
			res.source_position = pos_now;
			res.kept            = 1'b1;
			res.partition_point = PP_W'(cfg.base_offset) + PP_W'(kept_next);
			res.overflow        = ovf_q;
			res.last_result     = last_item && (rej_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			item_q      <= '0;
			kept_q      <= '0;
			rej_q       <= '0;
			drain_q     <= '0;
			ovf_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (last_item && (rej_next == '0)) begin
							// Nothing stored: the block ends here.
							item_q <= '0;
							kept_q <= '0;
							ovf_q  <= 1'b0;
						end else begin
							item_q <= item_q + CW'(room);
							kept_q <= kept_next;
							rej_q  <= rej_next;
							ovf_q  <= ovf_q | drop;
							if (last_item) begin
								state_q     <= ST_DRAIN;
								drain_q     <= '0;
								rd_valid_s1 <= 1'b0;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (drain_pop && rd_last_s1) begin
						state_q     <= ST_LOAD;
						item_q      <= '0;
						kept_q      <= '0;
						rej_q       <= '0;
						ovf_q       <= 1'b0;
						rd_valid_s1 <= 1'b0;
					end else if (rd_en) begin
						drain_q     <= drain_q + CW'(1);
						rd_valid_s1 <= 1'b1;
						rd_last_s1  <= (drain_q + CW'(1)) == rej_q;
					end else if (drain_pop) begin
						rd_valid_s1 <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_request_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (!in_ready && !wr_en))
		else $error("request taken or store written during drain");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		((CW+1)'(kept_q) + (CW+1)'(rej_q)) == (CW+1)'(item_q) || (state_q == ST_DRAIN))
		else $error("kept and rejected counts do not add up to item count");

	a_drain_has_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (rej_q != '0 && drain_q <= rej_q))
		else $error("drain running without stored positions");

	a_block_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_item && rej_next == '0) |=> (item_q == '0 && !ovf_q))
		else $error("block counters not cleared after final request");
`endif

endmodule

// File: rtl/flag_stable_partition.sv
// Flag stable partition. A kept position is registered in the output register and appears
// in the cycle after its request is taken. One flag word is taken per cycle while loading
// and the output register is free; after the final request the stored rejected positions
// drain through the position memory read port, one per cycle while the output register is
// free, with no request taken until the drain ends. Reset clears the counters and the
// output valid flag, and returns the registers to their reset values.
module flag_stable_partition #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fsp_pkg::APB_AW-1:0]  paddr,
	input  logic [fsp_pkg::APB_DW-1:0]  pwdata,
	output logic [fsp_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fsp_pkg::FLAG_W-1:0]  flag_word,
	input  logic                        last_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fsp_pkg::POS_W-1:0]   source_position,
	output logic                        kept,
	output logic [fsp_pkg::PP_W-1:0]    partition_point,
	output logic                        overflow,
	output logic                        last_result
);
	import fsp_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);

	cfg_t             cfg;
	res_t             res;
	res_t             res_q;
	logic             out_valid_q;
	logic             out_free;
	logic             push;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [POS_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [POS_W-1:0] rd_data;

	fsp_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsp_pos_ram #(
		.DEPTH (MAX_ITEMS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fsp_sequencer #(
		.MAX_ITEMS (MAX_ITEMS),
		.AW        (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.flag_word (flag_word),
		.last_item (last_item),
		.cfg       (cfg),
		.out_free  (out_free),
		.push      (push),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// Output register: refilled in the cycle that its contents are taken.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign source_position = res_q.source_position;
	assign kept            = res_q.kept;
	assign partition_point = res_q.partition_point;
	assign overflow        = res_q.overflow;
	assign last_result     = res_q.last_result;

endmodule

// File: sim/flag_stable_partition_tb.sv
// Self-checking testbench for the flag stable partition block.
// Drives blocks of flag words through a directed table and random blocks, predicts the
// emitted permutation itself and compares it; depends on fsp_pkg and the block's RTL.
module flag_stable_partition_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fsp_pkg::*;

	localparam int CAPACITY       = 64;
	localparam int RANDOM_ITEMS   = 430;
	localparam int QUIET_CYCLES   = 6;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int IDLE_PERCENT   = 29;

	typedef enum logic [1:0] {ROW_ITEM, ROW_MASK, ROW_BASE} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		logic [15:0]     value;
		logic            fin;
		bit              typed;
		res_t            want;
	} row_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                psel            = 1'b0;
	logic                penable         = 1'b0;
	logic                pwrite          = 1'b0;
	logic [APB_AW-1:0]   paddr           = '0;
	logic [APB_DW-1:0]   pwdata          = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic [FLAG_W-1:0]   flag_word       = '0;
	logic                last_item       = 1'b0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	logic [POS_W-1:0]    source_position;
	logic                kept;
	logic [PP_W-1:0]     partition_point;
	logic                overflow;
	logic                last_result;

	// Our own copy of the registers and of the partition state of the open block.
	logic [MASK_W-1:0]   mdl_mask = FLAG_MASK_RESET;
	logic [BASE_W-1:0]   mdl_base = BASE_OFFSET_RESET;
	int unsigned         blk_items;
	int unsigned         blk_kept;
	int unsigned         blk_rejected;
	bit                  blk_dropped;
	logic [POS_W-1:0]    rejected_store [CAPACITY];

	res_t                awaited_order [$];

	bit                  steady;
	int unsigned         mismatches;
	int unsigned         results_seen;
	int unsigned         requests_sent;
	int unsigned         blocks_closed;
	int unsigned         overflow_blocks;
	int unsigned         dropped_requests;
	int unsigned         register_writes;
	int unsigned         quiet_count;

	// Directed blocks: typed results are the ones that can be read off directly.
	row_t directed_rows [24] = '{
		'{ROW_ITEM, 16'h0000, 1'b0, 1'b1, '{6'd0, 1'b1, 17'd1, 1'b0, 1'b0}},
		'{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 16'hFF01, 1'b0, 1'b1, '{6'd2, 1'b1, 17'd2, 1'b0, 1'b0}},
		'{ROW_ITEM, 16'h00FE, 1'b1, 1'b0, '0},
		'{ROW_ITEM, 16'h0001, 1'b1, 1'b1, '{6'd0, 1'b1, 17'd1, 1'b0, 1'b1}},
		'{ROW_MASK, 16'h00FF, 1'b0, 1'b0, '0},
		'{ROW_BASE, 16'hFFFF, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 16'h0000, 1'b1, 1'b1, '{6'd0, 1'b1, 17'h10000, 1'b0, 1'b1}},
		'{ROW_ITEM, 16'h0100, 1'b0, 1'b1, '{6'd0, 1'b1, 17'h10000, 1'b0, 1'b0}},
		'{ROW_ITEM, 16'h8080, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 16'h7F00, 1'b0, 1'b1, '{6'd2, 1'b1, 17'h10001, 1'b0, 1'b0}},
		'{ROW_ITEM, 16'h0001, 1'b1, 1'b0, '0},
		'{ROW_MASK, 16'h0000, 1'b0, 1'b0, '0},
		'{ROW_BASE, 16'h0000, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 16'hFFFF, 1'b1, 1'b1, '{6'd0, 1'b1, 17'd1, 1'b0, 1'b1}},
		'{ROW_MASK, 16'h0001, 1'b0, 1'b0, '0},
		'{ROW_BASE, 16'h1234, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 16'h0002, 1'b0, 1'b1, '{6'd0, 1'b1, 17'h01235, 1'b0, 1'b0}},
		'{ROW_ITEM, 16'h0001, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 16'h00FF, 1'b1, 1'b0, '0},
		'{ROW_ITEM, 16'h0003, 1'b0, 1'b0, '0},
		// A kept final request with rejections pending must not carry the end marker.
		'{ROW_ITEM, 16'h0000, 1'b1, 1'b1, '{6'd1, 1'b1, 17'h01235, 1'b0, 1'b0}},
		'{ROW_MASK, 16'h00FE, 1'b0, 1'b0, '0},
		'{ROW_BASE, 16'h0000, 1'b0, 1'b0, '0}
	};

	flag_stable_partition #(
		.MAX_ITEMS(CAPACITY)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.flag_word       (flag_word),
		.last_item       (last_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.source_position (source_position),
		.kept            (kept),
		.partition_point (partition_point),
		.overflow        (overflow),
		.last_result     (last_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic res_t placed_position(logic [POS_W-1:0] pos, logic is_kept, logic fin);
		res_t r;
		r.source_position = pos;
		r.kept            = is_kept;
		r.partition_point = PP_W'(mdl_base) + PP_W'(blk_kept);
		r.overflow        = blk_dropped;
		r.last_result     = fin;
		return r;
	endfunction

	// Works out the results that one accepted request causes and queues them.
	function automatic void partition_step(logic [FLAG_W-1:0] word, logic fin);
		logic [POS_W-1:0] pos;
		if (blk_items < CAPACITY) begin
			pos = POS_W'(blk_items);
			blk_items++;
			if ((word[7:0] & mdl_mask) == '0) begin
				blk_kept++;
				awaited_order.push_back(placed_position(pos, 1'b1, fin && blk_rejected == 0));
			end else begin
				rejected_store[blk_rejected] = pos;
				blk_rejected++;
			end
		end else begin
			blk_dropped = 1'b1;
			dropped_requests++;
		end
		if (fin) begin
			for (int i = 0; i < blk_rejected; i++)
				awaited_order.push_back(placed_position(rejected_store[i], 1'b0,
					i + 1 == blk_rejected));
			if (blk_dropped)
				overflow_blocks++;
			blocks_closed++;
			blk_items    = 0;
			blk_kept     = 0;
			blk_rejected = 0;
			blk_dropped  = 1'b0;
		end
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t ns: mismatch on result %0d: %s", $realtime, results_seen, msg);
	endtask

	task automatic check_field(string field, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
	endtask

	// Lowers the request, waits for every expected result and lets the block go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_order.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Ends in the cycle after the access phase, so that a following write starts on a new edge.
	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FLAG_MASK: mdl_mask = value[MASK_W-1:0];
			REG_BASE_OFFSET: mdl_base = value[BASE_W-1:0];
			default: ;
		endcase
		register_writes++;
		@(posedge clk);
	endtask

	task automatic send_item(logic [FLAG_W-1:0] word, logic fin, bit typed, res_t want);
		int unsigned first_new;
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		flag_word <= word;
		last_item <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		// The typed result replaces the predicted one in the same step, before any pop.
		first_new = awaited_order.size();
		partition_step(word, fin);
		if (typed)
			awaited_order[first_new] = want;
		requests_sent++;
	endtask

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{source_position, kept, partition_point, overflow, last_result};
			results_seen++;
			if (awaited_order.size() == 0) begin
				report_mismatch($sformatf("result at position %0d with nothing awaited",
					got.source_position));
			end else begin
				want = awaited_order.pop_front();
				check_field("source_position", got.source_position, want.source_position);
				check_field("kept", got.kept, want.kept);
				check_field("partition_point", got.partition_point, want.partition_point);
				check_field("overflow", got.overflow, want.overflow);
				check_field("last_result", got.last_result, want.last_result);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count == WATCHDOG_LIMIT) begin
			$display("%0t ns: no request or result moved for %0d cycles", $realtime,
				WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned      random_sent;
		int unsigned      blk;
		int unsigned      len;
		int unsigned      kind;
		logic [FLAG_W-1:0] word;
		logic [MASK_W-1:0] new_mask;
		logic [BASE_W-1:0] new_base;
		random_sent = 0;
		blk         = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_MASK: begin
					settle();
					write_register(REG_FLAG_MASK, APB_DW'(directed_rows[i].value));
				end
				ROW_BASE: begin
					settle();
					write_register(REG_BASE_OFFSET, APB_DW'(directed_rows[i].value));
				end
				default: begin
					send_item(directed_rows[i].value, directed_rows[i].fin,
						directed_rows[i].typed, directed_rows[i].want);
				end
			endcase
		end

		// Random blocks: mostly short, some past capacity, and some entirely kept so that
		// the final request is dropped with nothing left to emit.
		while (random_sent < RANDOM_ITEMS) begin
			steady = (blk >= 6 && blk < 10);
			if (blk == 0 || $urandom_range(2) == 0) begin
				settle();
				case ($urandom_range(4))
					0: new_mask = '0;
					1: new_mask = 8'hFF;
					2: new_mask = FLAG_MASK_RESET;
					default: new_mask = MASK_W'($urandom_range(255));
				endcase
				case ($urandom_range(3))
					0: new_base = '0;
					1: new_base = 16'hFFFF;
					default: new_base = BASE_W'($urandom_range(65535));
				endcase
				if ($urandom_range(3) != 0)
					write_register(REG_FLAG_MASK, APB_DW'(new_mask));
				if ($urandom_range(3) != 0)
					write_register(REG_BASE_OFFSET, APB_DW'(new_base));
			end
			kind = $urandom_range(9);
			if (blk == 0)
				kind = 1;
			else if (blk == 1)
				kind = 0;
			case (kind)
				0: len = (blk == 1) ? CAPACITY : $urandom_range(CAPACITY + 6, CAPACITY - 4);
				1: len = $urandom_range(CAPACITY + 4, CAPACITY + 1);
				default: len = $urandom_range(16, 1);
			endcase
			for (int j = 0; j < len; j++) begin
				if (j != 0 && $urandom_range(39) == 0) begin
					settle();
					write_register(REG_FLAG_MASK, APB_DW'($urandom_range(255)));
				end
				word = FLAG_W'($urandom);
				if (kind == 1 || $urandom_range(1) == 0)
					word[7:0] = word[7:0] & ~mdl_mask;
				send_item(word, j == len - 1, 1'b0, '0);
				random_sent++;
			end
			blk++;
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (awaited_order.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_order.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_order.size()));

		$display("Ran %0d requests in %0d blocks, checked %0d results, %0d register writes.",
			requests_sent, blocks_closed, results_seen, register_writes);
		$display("%0d blocks overran capacity, %0d requests dropped, %0d mismatches.",
			overflow_blocks, dropped_requests, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
rtl/fsp_pkg.sv
rtl/fsp_apb_regs.sv
rtl/fsp_pos_ram.sv
rtl/fsp_sequencer.sv
rtl/flag_stable_partition.sv
sim/flag_stable_partition_tb.sv
